// ===== rtl/kmnc_pkg.sv =====
package kmnc_pkg;

    typedef enum logic [1:0] {
        OP_INIT     = 2'd0,
        OP_BEGIN    = 2'd1,
        OP_CLASSIFY = 2'd2,
        OP_UPDATE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_NUM_CLUSTERS = 2'd0,
        CFG_READ_LENGTH  = 2'd1,
        CFG_MIN_QUALITY  = 2'd2,
        CFG_MAX_QUALITY  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_GO,
        S_INIT_WAIT,
        S_INIT_FILL,
        S_CL_RUN,
        S_CL_SEARCH,
        S_UP_RD,
        S_UP_MUL,
        S_UP_GO,
        S_UP_WAIT
    } state_t;

    localparam int CENT_W  = 16;
    localparam int CNT_W   = 24;
    localparam int SUM_W   = 48;
    localparam int NUM_W   = 41;
    localparam int DEN_W   = 24;

    localparam logic [CNT_W-1:0] COUNT_MAX    = 24'hFFFFFF;
    localparam logic [SUM_W-1:0] SEARCH_LIMIT = 48'd655360000000;

endpackage

// ===== rtl/kmnc_div.sv =====
module kmnc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [kmnc_pkg::NUM_W-1:0] num,
    input  logic [kmnc_pkg::DEN_W-1:0] den,
    output logic                       done,
    output logic [kmnc_pkg::NUM_W-1:0] quot
);
    import kmnc_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_shift;
    logic             ge;

    // restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg, q_reg[NUM_W-1]};
    assign ge        = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? DEN_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== rtl/kmeans_nearest_centroid_update.sv =====
// Channel   Direction  Signals                                   Transfer
// command   in         start, busy, opcode, quality, read_class  start & !busy
// result    out        result_valid, assigned_class,             result_valid, one cycle
//                      class_changed
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid & cfg_ready
//
// Begin pass: stays idle. Classify: one squared distance per cluster, plus a nearest search over K at read end.
// Update: for a valid class, uses the 41-step serial divider for the running mean.
// Init: one divide per centroid, then one memory write per element.
// Reset loads default config and clears counts, sums and position; centroids hold garbage until init.
// Results cannot be stalled; cfg_ready is high only while idle.
module kmeans_nearest_centroid_update #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_LENGTH   = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] opcode,
    input  logic [7:0] quality,
    input  logic [4:0] read_class,
    output logic       result_valid,
    output logic [4:0] assigned_class,
    output logic       class_changed,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import kmnc_pkg::*;

    localparam int DEPTH = MAX_CLUSTERS * MAX_LENGTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_CLUSTERS);
    localparam int KW    = $clog2(MAX_CLUSTERS + 1);
    localparam int PW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LW    = $clog2(MAX_LENGTH + 1);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_LENGTH);

    // centroid store
    logic [CENT_W-1:0] cent_mem [DEPTH];
    logic [CENT_W-1:0] mem_rdata;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [CENT_W-1:0] mem_wdata;

    state_t state_reg, state_next;

    logic [4:0] k_cfg_reg;
    logic [7:0] len_cfg_reg;
    logic [7:0] min_cfg_reg;
    logic [7:0] max_cfg_reg;

    logic [CNT_W-1:0] counts_reg [MAX_CLUSTERS];
    logic [SUM_W-1:0] sums_reg   [MAX_CLUSTERS];
    logic [PW-1:0]    pos_reg;

    logic [7:0]       q_reg;
    logic [4:0]       cls_reg;

    logic [CW-1:0]    iss_reg;
    logic             iss_done_reg;
    logic             v1_reg, v2_reg;
    logic [CW-1:0]    c1_reg, c2_reg;
    logic [31:0]      sq_reg;

    logic [CW-1:0]    srch_reg;
    logic [SUM_W-1:0] best_reg;
    logic [4:0]       asg_reg;

    logic [CW-1:0]    row_reg;
    logic [PW-1:0]    fill_reg;
    logic [CENT_W-1:0] row_val_reg;

    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W+CENT_W-1:0] prod_reg;

    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic                div_done;
    logic [NUM_W-1:0]    div_quot;

    logic [KW-1:0]    k_eff;
    logic [LW-1:0]    len_eff;
    logic             last;
    logic             cls_ok;
    logic [CW-1:0]    cls_idx;
    logic             accept;
    logic [CW-1:0]    sum_idx;
    logic [SUM_W-1:0] sum_rd;
    logic             better;
    logic [CNT_W-1:0] cnt_rd;
    logic             span_neg;
    logic [7:0]       span_abs;
    logic [CW+7:0]    seed_prod;
    logic signed [16:0] diff;
    logic signed [33:0] sq_full;
    logic [CNT_W-1:0] nm1;
    logic [CENT_W-1:0] seed_val;

    always_comb
    begin
        if (int'(k_cfg_reg) < 2)
            k_eff = KW'(2);
        else if (int'(k_cfg_reg) > MAX_CLUSTERS)
            k_eff = KW'(MAX_CLUSTERS);
        else
            k_eff = KW'(k_cfg_reg);
        if (len_cfg_reg == 8'd0)
            len_eff = LW'(1);
        else if (int'(len_cfg_reg) > MAX_LENGTH)
            len_eff = LW'(MAX_LENGTH);
        else
            len_eff = LW'(len_cfg_reg);
    end

    assign last    = (int'(pos_reg) + 1) >= int'(len_eff);
    assign cls_ok  = (cls_reg != 5'd0) && (int'(cls_reg) <= int'(k_eff));
    assign cls_idx = CW'(cls_reg - 5'd1);
    assign accept  = start && !busy;
    assign busy    = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    assign sum_idx = (state_reg == S_CL_SEARCH) ? srch_reg : c2_reg;
    assign sum_rd  = sums_reg[sum_idx];
    assign better  = sum_rd < best_reg;
    assign cnt_rd  = counts_reg[cls_idx];

    assign span_neg  = max_cfg_reg < min_cfg_reg;
    assign span_abs  = span_neg ? (min_cfg_reg - max_cfg_reg) : (max_cfg_reg - min_cfg_reg);
    assign seed_prod = row_reg * span_abs;

    assign diff    = $signed({1'b0, q_reg, 8'b0}) - $signed({1'b0, mem_rdata});
    assign sq_full = diff * diff;
    assign nm1     = (cnt_rd == '0) ? '0 : cnt_rd - 1'b1;

    assign seed_val = CENT_W'({min_cfg_reg, 8'b0})
                    + (span_neg ? CENT_W'(-div_quot[CENT_W-1:0]) : div_quot[CENT_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cent_mem[mem_addr] <= mem_wdata;
        mem_rdata <= cent_mem[mem_addr];
    end

    kmnc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_addr   = '0;
        mem_wdata  = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(opcode))
                        OP_INIT:     state_next = S_INIT_GO;
                        OP_BEGIN:    state_next = S_IDLE;
                        OP_CLASSIFY: state_next = S_CL_RUN;
                        OP_UPDATE:   state_next = S_UP_RD;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_INIT_GO:
            begin
                div_start  = 1'b1;
                div_num    = NUM_W'({seed_prod, 8'b0}) + NUM_W'((k_eff - 1'b1) >> 1);
                div_den    = DEN_W'(k_eff - 1'b1);
                state_next = S_INIT_WAIT;
            end
            S_INIT_WAIT:
            begin
                if (div_done)
                    state_next = S_INIT_FILL;
            end
            S_INIT_FILL:
            begin
                mem_we    = 1'b1;
                mem_addr  = AW'(row_reg) * ROW_STRIDE + AW'(fill_reg);
                mem_wdata = row_val_reg;
                if (int'(fill_reg) == MAX_LENGTH - 1)
                begin
                    if (int'(row_reg) == int'(k_eff) - 1)
                        state_next = S_IDLE;
                    else
                        state_next = S_INIT_GO;
                end
            end
            S_CL_RUN:
            begin
                mem_addr = AW'(iss_reg) * ROW_STRIDE + AW'(pos_reg);
                if (iss_done_reg && !v1_reg && !v2_reg)
                    state_next = last ? S_CL_SEARCH : S_IDLE;
            end
            S_CL_SEARCH:
            begin
                if (int'(srch_reg) == int'(k_eff) - 1)
                    state_next = S_IDLE;
            end
            S_UP_RD:
            begin
                mem_addr   = AW'(cls_idx) * ROW_STRIDE + AW'(pos_reg);
                state_next = cls_ok ? S_UP_MUL : S_IDLE;
            end
            S_UP_MUL:
            begin
                state_next = S_UP_GO;
            end
            S_UP_GO:
            begin
                div_start  = 1'b1;
                div_num    = NUM_W'(prod_reg) + NUM_W'({q_reg, 8'b0}) + NUM_W'(n_reg >> 1);
                div_den    = n_reg;
                state_next = S_UP_WAIT;
            end
            S_UP_WAIT:
            begin
                mem_addr  = AW'(cls_idx) * ROW_STRIDE + AW'(pos_reg);
                mem_wdata = div_quot[CENT_W-1:0];
                if (div_done)
                begin
                    mem_we     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_cfg_reg    <= 5'd4;
            len_cfg_reg  <= 8'd100;
            min_cfg_reg  <= 8'd33;
            max_cfg_reg  <= 8'd74;
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                counts_reg[i] <= '0;
                sums_reg[i]   <= '0;
            end
            pos_reg      <= '0;
            result_valid <= 1'b0;
            iss_reg      <= '0;
            iss_done_reg <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            c1_reg       <= '0;
            c2_reg       <= '0;
            srch_reg     <= '0;
            row_reg      <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_NUM_CLUSTERS: k_cfg_reg   <= cfg_data[4:0];
                    CFG_READ_LENGTH:  len_cfg_reg <= cfg_data;
                    CFG_MIN_QUALITY:  min_cfg_reg <= cfg_data;
                    CFG_MAX_QUALITY:  max_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    iss_reg      <= '0;
                    iss_done_reg <= 1'b0;
                    v1_reg       <= 1'b0;
                    v2_reg       <= 1'b0;
                    srch_reg     <= '0;
                    row_reg      <= '0;
                    fill_reg     <= '0;
                    if (accept && (op_t'(opcode) == OP_INIT || op_t'(opcode) == OP_BEGIN))
                    begin
                        pos_reg <= '0;
                        for (int i = 0; i < MAX_CLUSTERS; i++)
                            sums_reg[i] <= '0;
                        if (op_t'(opcode) == OP_BEGIN)
                            for (int i = 0; i < MAX_CLUSTERS; i++)
                                counts_reg[i] <= '0;
                    end
                end
                S_INIT_FILL:
                begin
                    fill_reg <= (int'(fill_reg) == MAX_LENGTH - 1) ? '0 : fill_reg + 1'b1;
                    if (int'(fill_reg) == MAX_LENGTH - 1)
                        row_reg <= row_reg + 1'b1;
                end
                S_CL_RUN:
                begin
                    v1_reg <= !iss_done_reg;
                    c1_reg <= iss_reg;
                    v2_reg <= v1_reg;
                    c2_reg <= c1_reg;
                    if (!iss_done_reg)
                    begin
                        if (int'(iss_reg) == int'(k_eff) - 1)
                            iss_done_reg <= 1'b1;
                        else
                            iss_reg <= iss_reg + 1'b1;
                    end
                    if (v2_reg)
                        sums_reg[c2_reg] <= sum_rd + SUM_W'(sq_reg);
                    if (iss_done_reg && !v1_reg && !v2_reg && !last)
                        pos_reg <= pos_reg + 1'b1;
                end
                S_CL_SEARCH:
                begin
                    srch_reg <= srch_reg + 1'b1;
                    if (int'(srch_reg) == int'(k_eff) - 1)
                    begin
                        result_valid <= 1'b1;
                        pos_reg      <= '0;
                        for (int i = 0; i < MAX_CLUSTERS; i++)
                            sums_reg[i] <= '0;
                    end
                end
                S_UP_RD:
                begin
                    if (cls_ok && pos_reg == '0 && cnt_rd != COUNT_MAX)
                        counts_reg[cls_idx] <= cnt_rd + 1'b1;
                    if (!cls_ok)
                        pos_reg <= last ? '0 : pos_reg + 1'b1;
                end
                S_UP_WAIT:
                begin
                    if (div_done)
                        pos_reg <= last ? '0 : pos_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg   <= quality;
            cls_reg <= read_class;
        end
        if (v1_reg)
            sq_reg <= sq_full[31:0];
        if (state_reg == S_CL_RUN)
        begin
            best_reg <= SEARCH_LIMIT;
            asg_reg  <= cls_reg;
        end
        if (state_reg == S_CL_SEARCH)
        begin
            if (better)
            begin
                best_reg <= sum_rd;
                asg_reg  <= 5'(srch_reg) + 5'd1;
            end
            if (int'(srch_reg) == int'(k_eff) - 1)
            begin
                assigned_class <= better ? 5'(srch_reg) + 5'd1 : asg_reg;
                class_changed  <= (better ? 5'(srch_reg) + 5'd1 : asg_reg) != cls_reg;
            end
        end
        if (state_reg == S_INIT_WAIT && div_done)
            row_val_reg <= seed_val;
        if (state_reg == S_UP_MUL)
        begin
            prod_reg <= nm1 * mem_rdata;
            n_reg    <= (cnt_rd == '0) ? CNT_W'(1) : cnt_rd;
        end
    end

endmodule

// ===== rtl/kmnc_checker.sv =====
module kmnc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] opcode,
    input logic       result_valid
);
    import kmnc_pkg::*;

    // multi-cycle commands always raise busy
    a_work_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode != OP_BEGIN) |=> busy)
        else $error("busy not raised after command transfer");

    a_begin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_BEGIN) |=> !busy)
        else $error("begin pass held busy");

    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy && $past(busy))
        else $error("result outside end of classify");

endmodule

bind kmeans_nearest_centroid_update kmnc_checker u_kmnc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .result_valid (result_valid)
);
